// ----- hdl/stq_pkg.sv -----
// types and constants shared by the sorted timer queue modules
// no dependencies
package stq_pkg;

	localparam int MaxResults = 16;
	localparam int FcntW = $clog2(MaxResults + 1);
	localparam int FidxW = $clog2(MaxResults);

	typedef enum logic [1:0] {
		MODE_START   = 2'd0,
		MODE_STOP    = 2'd1,
		MODE_RESTART = 2'd2,
		MODE_TICK    = 2'd3
	} mode_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_UNUSED = 2'd1;
	localparam logic [1:0] ST_INUSE  = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  slot;
		logic        is_periodic;
		logic [63:0] time_us;
		logic [63:0] now_us;
	} req_t;

	typedef struct packed {
		logic        fired;
		logic [3:0]  fired_slot;
		logic [1:0]  status;
		logic        next_valid;
		logic [63:0] next_expiry_us;
		logic        last;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_RA_RD,
		S_RA_ARM,
		S_INS_RD,
		S_INS_CMP,
		S_TK_RD,
		S_TK_CHK,
		S_EM_RD,
		S_EM_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load_in;
		logic       rd_head;
		logic       rd_walk;
		logic       rd_per;
		logic       start_arm;
		logic       rearm;
		logic       remove_cur;
		logic       free_cur;
		logic       tick_fire;
		logic       walk_step;
		logic       set_st;
		logic [1:0] st_val;
		logic       out_single;
		logic       out_fire;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic is_start;
		logic is_stop;
		logic slot_bad;
		logic used_cur;
		logic per_cur;
		logic len_zero;
		logic fcnt_full;
		logic fcnt_zero;
		logic head_due;
		logic per_head;
		logic walk_done;
		logic out_free;
		logic last_fire;
	} sts_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

endpackage

// ----- hdl/stq_ctrl.sv -----
// sequencer of the sorted timer queue
// depends on stq_pkg
module stq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  stq_pkg::sts_t sts,
	output stq_pkg::cmd_t cmd
);
	import stq_pkg::*;

	state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (req_valid) state_nx = S_DEC;
			S_DEC: begin
				if (sts.is_tick) state_nx = S_TK_RD;
				else if (sts.slot_bad) state_nx = S_EM_RD;
				else if (sts.is_start) state_nx = sts.used_cur ? S_EM_RD : S_INS_RD;
				else if (!sts.used_cur || !sts.per_cur || sts.is_stop) state_nx = S_EM_RD;
				else state_nx = S_RA_RD;
			end
			S_RA_RD:  state_nx = S_RA_ARM;
			S_RA_ARM: state_nx = S_INS_RD;
			S_INS_RD: state_nx = S_INS_CMP;
			S_INS_CMP: begin
				if (sts.walk_done) state_nx = sts.is_tick ? S_TK_RD : S_EM_RD;
				else state_nx = S_INS_RD;
			end
			S_TK_RD: state_nx = (sts.len_zero || sts.fcnt_full) ? S_EM_RD : S_TK_CHK;
			S_TK_CHK: begin
				if (!sts.head_due) state_nx = S_EM_RD;
				else state_nx = sts.per_head ? S_RA_RD : S_TK_RD;
			end
			S_EM_RD: state_nx = S_EM_OUT;
			S_EM_OUT: begin
				if (sts.out_free) begin
					if (!sts.is_tick || sts.fcnt_zero || sts.last_fire) state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				cmd.load_in = req_valid;
			end
			S_DEC: begin
				cmd.set_st = 1'b1;
				cmd.st_val = ST_OK;
				if (sts.is_tick) begin
					cmd.st_val = ST_OK;
				end else if (sts.slot_bad) begin
					cmd.st_val = ST_UNUSED;
				end else if (sts.is_start) begin
					if (sts.used_cur) cmd.st_val = ST_INUSE;
					else cmd.start_arm = 1'b1;
				end else if (!sts.used_cur) begin
					cmd.st_val = ST_UNUSED;
				end else begin
					cmd.remove_cur = 1'b1;
					cmd.free_cur = !sts.per_cur;
				end
			end
			S_RA_RD:   cmd.rd_per = 1'b1;
			S_RA_ARM:  cmd.rearm = 1'b1;
			S_INS_RD:  cmd.rd_walk = 1'b1;
			S_INS_CMP: cmd.walk_step = 1'b1;
			S_TK_RD:   cmd.rd_head = 1'b1;
			S_TK_CHK:  cmd.tick_fire = sts.head_due;
			S_EM_RD:   cmd.rd_head = 1'b1;
			S_EM_OUT: begin
				if (sts.out_free) begin
					if (sts.is_tick && !sts.fcnt_zero) cmd.out_fire = 1'b1;
					else cmd.out_single = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- hdl/stq_dp.sv -----
// datapath of the sorted timer queue: ordered list, slot tables, fire buffer, output register
// depends on stq_pkg
module stq_dp #(
	parameter int NUM_TIMERS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  stq_pkg::req_t req,
	input  stq_pkg::cmd_t cmd,
	output stq_pkg::sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output stq_pkg::rsp_t rsp
);
	import stq_pkg::*;

	localparam int IW = $clog2(NUM_TIMERS);
	localparam int CW = $clog2(NUM_TIMERS + 1);

	req_t              in_q;
	logic [IW-1:0]     cur_q;
	logic [IW-1:0]     order_q [NUM_TIMERS];
	logic [CW-1:0]     len_q;
	logic [CW-1:0]     pos_q;
	logic [NUM_TIMERS-1:0] used_q, per_q, done_q;
	logic [63:0]       exp_mem [NUM_TIMERS];
	logic [63:0]       per_mem [NUM_TIMERS];
	logic [63:0]       exp_rd_q, per_rd_q, e_q;
	logic [3:0]        fbuf_q [MaxResults];
	logic [FcntW-1:0]  fcnt_q, kcnt_q;
	logic [1:0]        st_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [IW-1:0] head, walk_idx, hit_idx;
	logic          hit;
	logic [63:0]   arm_e, rearm_e;
	logic          walk_go;
	logic          rm_en;

	assign head     = order_q[0];
	assign walk_idx = (pos_q == '0) ? '0 : IW'(pos_q - CW'(1));
	assign arm_e    = in_q.is_periodic ? sat_add(in_q.now_us, in_q.time_us) : in_q.time_us;
	assign rearm_e  = sat_add(in_q.now_us, per_rd_q);
	assign walk_go  = (pos_q != '0) && (exp_rd_q > e_q);

	// find the list position of the current slot, or the head on a fire
	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		if (cmd.tick_fire) begin
			hit = 1'b1;
		end else begin
			for (int j = 0; j < NUM_TIMERS; j++) begin
				if (CW'(j) < len_q && order_q[j] == cur_q) begin
					hit = 1'b1;
					hit_idx = hit_idx | IW'(j);
				end
			end
		end
	end
	assign rm_en = (cmd.remove_cur || cmd.tick_fire) && hit;

	// status to the controller
	always_comb begin
		sts.is_tick   = in_q.mode == MODE_TICK;
		sts.is_start  = in_q.mode == MODE_START;
		sts.is_stop   = in_q.mode == MODE_STOP;
		sts.slot_bad  = 32'(in_q.slot) >= NUM_TIMERS;
		sts.used_cur  = used_q[cur_q];
		sts.per_cur   = per_q[cur_q];
		sts.len_zero  = len_q == '0;
		sts.fcnt_full = fcnt_q == FcntW'(MaxResults);
		sts.fcnt_zero = fcnt_q == '0;
		sts.head_due  = (in_q.now_us >= exp_rd_q) && !done_q[head];
		sts.per_head  = per_q[head];
		sts.walk_done = !walk_go;
		sts.out_free  = !rsp_valid_q || !rsp_stall;
		sts.last_fire = kcnt_q == fcnt_q - FcntW'(1);
	end

	// item register and payload state
	always_ff @(posedge clk) begin
		if (cmd.load_in) in_q <= req;
		if (cmd.rd_head) exp_rd_q <= exp_mem[head];
		if (cmd.rd_walk) exp_rd_q <= exp_mem[order_q[walk_idx]];
		if (cmd.rd_per) per_rd_q <= per_mem[cur_q];
		if (cmd.start_arm) e_q <= arm_e;
		if (cmd.rearm) e_q <= rearm_e;
		if (cmd.tick_fire) fbuf_q[fcnt_q[FidxW-1:0]] <= 4'(head);
		if (cmd.set_st) st_q <= cmd.st_val;
	end

	// timer tables
	always_ff @(posedge clk) begin
		if (cmd.start_arm) begin
			exp_mem[cur_q] <= arm_e;
			if (in_q.is_periodic) per_mem[cur_q] <= in_q.time_us;
		end
		if (cmd.rearm) exp_mem[cur_q] <= rearm_e;
	end

	// ordered list: removal shifts the tail up, the insertion walk shifts down
	always_ff @(posedge clk) begin
		if (rm_en) begin
			for (int j = 0; j < NUM_TIMERS - 1; j++)
				if (IW'(j) >= hit_idx) order_q[j] <= order_q[j + 1];
		end else if (cmd.walk_step) begin
			if (walk_go) order_q[pos_q[IW-1:0]] <= order_q[walk_idx];
			else order_q[pos_q[IW-1:0]] <= cur_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			len_q <= '0;
			pos_q <= '0;
			used_q <= '0;
			per_q <= '0;
			done_q <= '0;
			fcnt_q <= '0;
			kcnt_q <= '0;
		end else begin
			if (cmd.load_in) begin
				cur_q <= IW'(req.slot);
				done_q <= '0;
				fcnt_q <= '0;
				kcnt_q <= '0;
			end
			if (cmd.start_arm) begin
				used_q[cur_q] <= 1'b1;
				per_q[cur_q] <= in_q.is_periodic;
				pos_q <= len_q;
			end
			if (cmd.rearm) pos_q <= len_q;
			if (rm_en) len_q <= len_q - CW'(1);
			if (cmd.free_cur) used_q[cur_q] <= 1'b0;
			if (cmd.tick_fire) begin
				cur_q <= head;
				done_q[head] <= 1'b1;
				fcnt_q <= fcnt_q + FcntW'(1);
				if (!per_q[head]) used_q[head] <= 1'b0;
			end
			if (cmd.walk_step) begin
				if (walk_go) pos_q <= pos_q - CW'(1);
				else len_q <= len_q + CW'(1);
			end
			if (cmd.out_fire) kcnt_q <= kcnt_q + FcntW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_valid_q <= 1'b0;
		else if (cmd.out_single || cmd.out_fire) rsp_valid_q <= 1'b1;
		else if (!rsp_stall) rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_single || cmd.out_fire) begin
			rsp_q.fired          <= cmd.out_fire;
			rsp_q.fired_slot     <= cmd.out_fire ? fbuf_q[kcnt_q[FidxW-1:0]] : 4'd0;
			rsp_q.status         <= st_q;
			rsp_q.next_valid     <= len_q != '0;
			rsp_q.next_expiry_us <= (len_q != '0) ? exp_rd_q : 64'd0;
			rsp_q.last           <= cmd.out_single || sts.last_fire;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hdl/sorted_timer_queue_core.sv -----
// top level of the sorted timer queue: controller plus datapath
// depends on stq_pkg, stq_ctrl, stq_dp
//
// One item is handled at a time. Stop and failed commands go from decode
// straight to reading the head and emitting the result; a tick with nothing
// due first reads the head (S_TK_RD) and checks it (S_TK_CHK) unless the list
// is empty. Each list insertion (start, periodic restart, each periodic fire)
// walks from the tail toward the head, reading (S_INS_RD) and then comparing
// (S_INS_CMP) one entry per step, as the expiry table has one registered read
// port. A periodic restart or periodic fire first fetches the period and arms
// (S_RA_RD, S_RA_ARM), and each fire of a tick passes through S_TK_RD and S_TK_CHK.
// A tick's results all carry the next expiry as it stands after the whole tick.
// The last result waits in an output register while the next item is taken.
module sorted_timer_queue_core #(
	parameter int NUM_TIMERS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  stq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output stq_pkg::rsp_t rsp
);
	import stq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	stq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	stq_dp #(
		.NUM_TIMERS (NUM_TIMERS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
